// File: src/mwm_pkg.sv
// mwm_pkg: shared types, widths, codes and the microcode table of the
// mecanum wheel mixer. No dependencies.
`default_nettype none

package mwm_pkg;

  localparam int DUTY_BITS  = 8;
  localparam int IN_W       = 16;
  localparam int GAIN_W     = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int NUM_WHEELS = 4;
  localparam int WHEEL_W    = 2;
  localparam int PROD_W     = 34;
  localparam int S_W        = 36;
  localparam int MAG_W      = 35;
  localparam int N_W        = MAG_W + DUTY_BITS;
  localparam int CNT_W      = $clog2(DUTY_BITS);
  localparam int PC_W       = 5;

  localparam logic [DUTY_BITS-1:0] DUTY_FULL = {DUTY_BITS{1'b1}};
  localparam logic [MAG_W-1:0]     ONE_Q31   = MAG_W'(1) << 31;
  localparam logic signed [IN_W:0] INV_SQRT2 = 17'sd46341;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'd1;

  typedef enum logic [1:0] {
    FUNC_MOVE = 2'd0,
    FUNC_STOP = 2'd1,
    FUNC_SET  = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    OP_DISPATCH,
    OP_MUL_PLUS,
    OP_MUL_MINUS,
    OP_MUL_ROT,
    OP_MIX,
    OP_MAX,
    OP_DEN,
    OP_LOAD_MIX,
    OP_LOAD_SET,
    OP_DIV,
    OP_STORE_MIX,
    OP_STORE_SET,
    OP_CLEAR,
    OP_FINISH
  } op_e;

  typedef enum logic [1:0] {
    C_NEVER,
    C_ALWAYS,
    C_DIV_BUSY,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e              op;
    logic [WHEEL_W-1:0] wheel;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } ctrl_word_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  typedef struct packed {
    logic                 rev;
    logic [DUTY_BITS-1:0] duty;
  } drive_t;

  localparam logic [PC_W-1:0] PC_MOVE   = 5'd1;
  localparam logic [PC_W-1:0] PC_FINISH = 5'd25;
  localparam logic [PC_W-1:0] PC_STOP   = 5'd26;
  localparam logic [PC_W-1:0] PC_SET    = 5'd27;

  function automatic ctrl_word_t mk(input op_e op, input logic [WHEEL_W-1:0] wheel,
                                    input cond_e cond, input logic [PC_W-1:0] target);
    ctrl_word_t w;
    w.op     = op;
    w.wheel  = wheel;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(input func_e func);
    logic [PC_W-1:0] pc;
    case (func)
      FUNC_MOVE: pc = PC_MOVE;
      FUNC_STOP: pc = PC_STOP;
      FUNC_SET:  pc = PC_SET;
      default:   pc = PC_FINISH;
    endcase
    return pc;
  endfunction

  // move: products, mix, max search, denominator, then load/divide/store per wheel
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      5'd0:  w = mk(OP_DISPATCH,  2'd0, C_NEVER,    '0);
      5'd1:  w = mk(OP_MUL_PLUS,  2'd0, C_NEVER,    '0);
      5'd2:  w = mk(OP_MUL_MINUS, 2'd0, C_NEVER,    '0);
      5'd3:  w = mk(OP_MUL_ROT,   2'd0, C_NEVER,    '0);
      5'd4:  w = mk(OP_MIX,       2'd0, C_NEVER,    '0);
      5'd5:  w = mk(OP_MIX,       2'd1, C_NEVER,    '0);
      5'd6:  w = mk(OP_MIX,       2'd2, C_NEVER,    '0);
      5'd7:  w = mk(OP_MIX,       2'd3, C_NEVER,    '0);
      5'd8:  w = mk(OP_MAX,       2'd0, C_NEVER,    '0);
      5'd9:  w = mk(OP_MAX,       2'd1, C_NEVER,    '0);
      5'd10: w = mk(OP_MAX,       2'd2, C_NEVER,    '0);
      5'd11: w = mk(OP_MAX,       2'd3, C_NEVER,    '0);
      5'd12: w = mk(OP_DEN,       2'd0, C_NEVER,    '0);
      5'd13: w = mk(OP_LOAD_MIX,  2'd0, C_NEVER,    '0);
      5'd14: w = mk(OP_DIV,       2'd0, C_DIV_BUSY, 5'd14);
      5'd15: w = mk(OP_STORE_MIX, 2'd0, C_NEVER,    '0);
      5'd16: w = mk(OP_LOAD_MIX,  2'd1, C_NEVER,    '0);
      5'd17: w = mk(OP_DIV,       2'd1, C_DIV_BUSY, 5'd17);
      5'd18: w = mk(OP_STORE_MIX, 2'd1, C_NEVER,    '0);
      5'd19: w = mk(OP_LOAD_MIX,  2'd2, C_NEVER,    '0);
      5'd20: w = mk(OP_DIV,       2'd2, C_DIV_BUSY, 5'd20);
      5'd21: w = mk(OP_STORE_MIX, 2'd2, C_NEVER,    '0);
      5'd22: w = mk(OP_LOAD_MIX,  2'd3, C_NEVER,    '0);
      5'd23: w = mk(OP_DIV,       2'd3, C_DIV_BUSY, 5'd23);
      5'd24: w = mk(OP_STORE_MIX, 2'd3, C_NEVER,    '0);
      5'd25: w = mk(OP_FINISH,    2'd0, C_OUT_BUSY, PC_FINISH);
      5'd26: w = mk(OP_CLEAR,     2'd0, C_ALWAYS,   PC_FINISH);
      5'd27: w = mk(OP_LOAD_SET,  2'd0, C_NEVER,    '0);
      5'd28: w = mk(OP_DIV,       2'd0, C_DIV_BUSY, 5'd28);
      5'd29: w = mk(OP_STORE_SET, 2'd0, C_ALWAYS,   PC_FINISH);
      default: w = mk(OP_FINISH,  2'd0, C_OUT_BUSY, PC_FINISH);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: src/mwm_cmd_if.sv
// mwm_cmd_if: drive command channel, valid/ready plus command fields.
// Depends on mwm_pkg for field widths.
`default_nettype none

interface mwm_cmd_if
  import mwm_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [1:0]             func;
  logic signed [IN_W-1:0] strafe;
  logic signed [IN_W-1:0] forward;
  logic signed [IN_W-1:0] turn;
  logic [WHEEL_W-1:0]     wheel_select;
  logic signed [IN_W-1:0] wheel_speed;

  modport source (output valid, func, strafe, forward, turn, wheel_select, wheel_speed,
                  input ready);
  modport sink (input valid, func, strafe, forward, turn, wheel_select, wheel_speed,
                output ready);
endinterface

`default_nettype wire

// File: src/mwm_duty_if.sv
// mwm_duty_if: wheel duty result channel, valid/ready plus eight duties.
// Depends on mwm_pkg for the duty width.
`default_nettype none

interface mwm_duty_if
  import mwm_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [DUTY_BITS-1:0] fl_fwd_duty;
  logic [DUTY_BITS-1:0] fl_rev_duty;
  logic [DUTY_BITS-1:0] fr_fwd_duty;
  logic [DUTY_BITS-1:0] fr_rev_duty;
  logic [DUTY_BITS-1:0] bl_fwd_duty;
  logic [DUTY_BITS-1:0] bl_rev_duty;
  logic [DUTY_BITS-1:0] br_fwd_duty;
  logic [DUTY_BITS-1:0] br_rev_duty;

  modport source (output valid, fl_fwd_duty, fl_rev_duty, fr_fwd_duty, fr_rev_duty,
                  bl_fwd_duty, bl_rev_duty, br_fwd_duty, br_rev_duty,
                  input ready);
  modport sink (input valid, fl_fwd_duty, fl_rev_duty, fr_fwd_duty, fr_rev_duty,
                bl_fwd_duty, bl_rev_duty, br_fwd_duty, br_rev_duty,
                output ready);
endinterface

`default_nettype wire

// File: src/mwm_div.sv
// mwm_div: restoring divider, one quotient bit per step, DUTY_BITS steps.
// Depends on mwm_pkg; driven by the sequencer in the top level.
`default_nettype none

module mwm_div
  import mwm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire div_ctrl_t            ctrl_i,
  input  wire logic [N_W-1:0]       num_i,
  input  wire logic [N_W-1:0]       den_i,
  output logic [DUTY_BITS-1:0]      quo_o,
  output logic                      last_o
);

  logic [N_W-1:0]       rem_q, rem_d;
  logic [N_W-1:0]       dsh_q, dsh_d;
  logic [DUTY_BITS-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 ge;

  assign ge = rem_q >= dsh_q;

  always_comb begin
    rem_d = rem_q;
    dsh_d = dsh_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      rem_d = num_i;
      dsh_d = den_i;
      quo_d = '0;
      cnt_d = CNT_W'(DUTY_BITS - 1);
    end else if (ctrl_i.step) begin
      rem_d = ge ? rem_q - dsh_q : rem_q;
      dsh_d = dsh_q >> 1;
      quo_d = {quo_q[DUTY_BITS-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign quo_o  = quo_q;
  assign last_o = (cnt_q == '0);

endmodule

`default_nettype wire

// File: src/mecanum_wheel_mixer_pwm_top.sv
// mecanum_wheel_mixer_pwm_top: microcoded mixer, normaliser and PWM encoder
// for four mecanum wheels. Depends on mwm_pkg, mwm_cmd_if, mwm_duty_if, mwm_div.
// The per-wheel divide (8 steps) dominates the time from command transaction
// to result valid for move and for set one wheel.
// One command at a time; the next is taken the cycle after the result is
// registered, while that result may still wait in the output register.
// Reset (async, active low): all wheels stopped, simple mixing, turn gain 0.6.
`default_nettype none

module mecanum_wheel_mixer_pwm_top
  import mwm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  mwm_cmd_if.sink                   cmd,
  mwm_duty_if.source                duty
);

  logic                   mode_q;
  logic [GAIN_W-1:0]      gain_q;
  logic                   busy_q;
  logic [PC_W-1:0]        pc_q, pc_d;
  logic                   out_valid_q;
  drive_t                 drive_q [NUM_WHEELS];

  func_e                  func_q;
  logic signed [IN_W-1:0] x_q, y_q, r_q, spd_q;
  logic [WHEEL_W-1:0]     sel_q;
  logic signed [PROD_W-1:0] plus_q, minus_q, rot_q;
  logic signed [S_W-1:0]  s_q [NUM_WHEELS];
  logic [MAG_W-1:0]       m_q, den_q;
  logic                   sign_q;
  logic [DUTY_BITS-1:0]   out_duty_q [2*NUM_WHEELS];

  ctrl_word_t             cw;
  logic                   accept, out_busy, jump, fin_fire;
  logic signed [IN_W:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                   pos_x, pos_r;
  logic signed [IN_W+1:0] sum_simple;
  logic signed [S_W-1:0]  s_simple, s_polar, rot4, s_mix, s_cur;
  logic [MAG_W-1:0]       mag_cur, mag_set, mag_num;
  logic [IN_W:0]          spd_abs;
  logic [N_W-1:0]         div_num, div_den;
  div_ctrl_t              div_ctrl;
  logic [DUTY_BITS-1:0]   quo;
  logic                   div_last;
  drive_t                 enc;

  assign cw       = ucode(pc_q);
  assign accept   = cmd.valid && cmd.ready;
  assign out_busy = out_valid_q && !duty.ready;
  assign fin_fire = busy_q && (cw.op == OP_FINISH) && !out_busy;

  always_comb begin
    case (cw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_DIV_BUSY: jump = !div_last;
      C_OUT_BUSY: jump = out_busy;
      default:    jump = 1'b0;
    endcase
  end

  always_comb begin
    if (cw.op == OP_DISPATCH) begin
      pc_d = entry_pc(func_q);
    end else if (jump) begin
      pc_d = cw.target;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  // shared multiplier
  always_comb begin
    case (cw.op)
      OP_MUL_PLUS: begin
        mul_a = (IN_W+1)'(x_q) + (IN_W+1)'(y_q);
        mul_b = INV_SQRT2;
      end
      OP_MUL_MINUS: begin
        mul_a = (IN_W+1)'(y_q) - (IN_W+1)'(x_q);
        mul_b = INV_SQRT2;
      end
      default: begin
        mul_a = $signed({1'b0, gain_q});
        mul_b = (IN_W+1)'(r_q);
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // wheel mix, signs per wheel position
  always_comb begin
    pos_x      = (cw.wheel == 2'd0) || (cw.wheel == 2'd3);
    pos_r      = (cw.wheel == 2'd0) || (cw.wheel == 2'd2);
    sum_simple = (IN_W+2)'(y_q)
               + (pos_x ? (IN_W+2)'(x_q) : -(IN_W+2)'(x_q))
               + (pos_r ? (IN_W+2)'(r_q) : -(IN_W+2)'(r_q));
    s_simple   = S_W'($signed({sum_simple, 16'h0000}));
    rot4       = S_W'(rot_q) <<< 2;
    s_polar    = S_W'(pos_x ? plus_q : minus_q) + (pos_r ? rot4 : -rot4);
    s_mix      = mode_q ? s_polar : s_simple;
  end

  assign s_cur   = s_q[cw.wheel];
  assign mag_cur = MAG_W'(s_cur[S_W-1] ? -s_cur : s_cur);
  assign spd_abs = spd_q[IN_W-1] ? -(IN_W+1)'(spd_q) : (IN_W+1)'(spd_q);
  assign mag_set = MAG_W'(spd_abs) << 16;
  assign mag_num = (cw.op == OP_LOAD_SET) ? mag_set : mag_cur;
  assign div_num = (N_W'(mag_num) << DUTY_BITS) - N_W'(mag_num);
  assign div_den = N_W'((cw.op == OP_LOAD_SET) ? ONE_Q31 : den_q) << (DUTY_BITS - 1);

  assign div_ctrl.load = busy_q && ((cw.op == OP_LOAD_MIX) || (cw.op == OP_LOAD_SET));
  assign div_ctrl.step = busy_q && (cw.op == OP_DIV);

  mwm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (div_num),
    .den_i  (div_den),
    .quo_o  (quo),
    .last_o (div_last)
  );

  always_comb begin
    enc.duty = quo;
    enc.rev  = sign_q && (quo != '0);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      gain_q      <= GAIN_W'(9830);
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        drive_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE: mode_q <= cfg_data_i[0];
          CFG_GAIN: gain_q <= cfg_data_i[GAIN_W-1:0];
          default:  ;
        endcase
      end
      if (accept) begin
        busy_q <= 1'b1;
        pc_q   <= '0;
      end else if (busy_q) begin
        pc_q <= pc_d;
        case (cw.op)
          OP_STORE_MIX: drive_q[cw.wheel] <= enc;
          OP_STORE_SET: drive_q[sel_q] <= enc;
          OP_CLEAR: begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
              drive_q[i] <= '0;
            end
          end
          OP_FINISH: begin
            if (!out_busy) begin
              busy_q <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (duty.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(cmd.func);
      x_q    <= cmd.strafe;
      y_q    <= cmd.forward;
      r_q    <= cmd.turn;
      sel_q  <= cmd.wheel_select;
      spd_q  <= cmd.wheel_speed;
    end
    if (busy_q) begin
      case (cw.op)
        OP_DISPATCH:  m_q <= '0;
        OP_MUL_PLUS:  plus_q <= mul_p;
        OP_MUL_MINUS: minus_q <= mul_p;
        OP_MUL_ROT:   rot_q <= mul_p;
        OP_MIX:       s_q[cw.wheel] <= s_mix;
        OP_MAX:       m_q <= (mag_cur > m_q) ? mag_cur : m_q;
        OP_DEN:       den_q <= (m_q > ONE_Q31) ? m_q : ONE_Q31;
        OP_LOAD_MIX:  sign_q <= s_cur[S_W-1];
        OP_LOAD_SET:  sign_q <= spd_q[IN_W-1];
        default: ;
      endcase
    end
    if (fin_fire) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        out_duty_q[2*i]   <= drive_q[i].rev ? '0 : drive_q[i].duty;
        out_duty_q[2*i+1] <= drive_q[i].rev ? drive_q[i].duty : '0;
      end
    end
  end

  assign cmd.ready        = !busy_q;
  assign duty.valid       = out_valid_q;
  assign duty.fl_fwd_duty = out_duty_q[0];
  assign duty.fl_rev_duty = out_duty_q[1];
  assign duty.fr_fwd_duty = out_duty_q[2];
  assign duty.fr_rev_duty = out_duty_q[3];
  assign duty.bl_fwd_duty = out_duty_q[4];
  assign duty.bl_rev_duty = out_duty_q[5];
  assign duty.br_fwd_duty = out_duty_q[6];
  assign duty.br_rev_duty = out_duty_q[7];

endmodule

`default_nettype wire
